/* hdl/sgnms_pkg.sv */
// Shared types and constants for the Sobel gradient / non-maximum suppression core.
// No dependencies; imported by the core and the port-level checker.
package sgnms_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HEIGHT    = 4096;
    localparam int MIN_SIZE      = 3;
    localparam int GRAD_LIMIT    = 510;
    localparam int MAG_MAX       = 1020;
    localparam int ROW_W         = 13;
    localparam int OUT_DEPTH     = 16;
    localparam int OUT_CNT_W     = $clog2(OUT_DEPTH + 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_LEVEL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_LEVEL   = 3'd3;

    localparam logic [10:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [12:0] FRAME_HEIGHT_RST = 13'd480;
    localparam logic [9:0]  LOW_LEVEL_RST    = 10'd100;
    localparam logic [9:0]  HIGH_LEVEL_RST   = 10'd300;

    typedef enum logic [1:0] {
        DIR_VERT  = 2'd0,
        DIR_HORZ  = 2'd1,
        DIR_SLASH = 2'd2,
        DIR_BACK  = 2'd3
    } dir_t;

    // one column of the 3x3 pixel window
    typedef struct packed {
        logic [7:0] top;
        logic [7:0] mid;
        logic [7:0] bot;
    } pix_col_t;

    // one column of the 3x3 magnitude window, with the direction of the middle cell
    typedef struct packed {
        logic [9:0] top;
        logic [9:0] mid;
        logic [9:0] bot;
        dir_t       dir;
    } mag_col_t;

    typedef struct packed {
        logic [9:0] mag;
        dir_t       dir;
        logic       lo;
        logic       hi;
        logic       last;
    } out_beat_t;

endpackage

/* hdl/sgnms_ram.sv */
// Generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
module sgnms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hdl/sobel_gradient_nonmax_suppress_core.sv */
// Sobel gradient and non-maximum suppression core, top level.
// Depends on sgnms_pkg and sgnms_ram.
//
// Usage:
//   Input channel (in_valid/in_ready): one beat per pixel in raster order
//   (req_type 0) or a flush tick (req_type 1). After a frame's last pixel,
//   2*W+2 flush ticks drain it. Flush ticks while pixels are still due, or
//   between frames, are taken and dropped. Frame size is latched at the first
//   pixel of each frame; thresholds act at once.
//   Output channel (out_valid/out_ready): one beat per pixel with the
//   suppressed magnitude, its direction class, the two threshold flags and
//   frame_last on the frame's final pixel.
//   Config channel (cfg_valid/cfg_ready): always ready; user must write it while idle (not enforced).
// Throughput: one input beat per clock while in_ready is high. Pixel p's
//   result leaves the seven-stage pipeline after the beat of position p+2W+2.
//   Two line memories (pixels, magnitudes) are read and written back once per
//   beat, at column addresses that never meet within 3 beats.
// Stall: results queue in a 16-beat output buffer; in_ready drops only when
//   buffered plus in-flight results reach 16.
// Reset: clears the position, the pipeline and the buffer; line memories
//   need no clearing since every entry is written in a frame before use.
module sobel_gradient_nonmax_suppress_core #(
    parameter int MAX_WIDTH = sgnms_pkg::MAX_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             req_type,
    input  logic [7:0]                       pixel_value,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [9:0]                       edge_magnitude,
    output logic [1:0]                       edge_direction,
    output logic                             above_low,
    output logic                             above_high,
    output logic                             frame_last,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sgnms_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sgnms_pkg::CFG_DATA_W-1:0] cfg_data
);

    import sgnms_pkg::*;

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);

    typedef struct packed {
        logic          c0;
        logic          c1;
        logic          ptop;
        logic          pbot;
        logic          q_ok;
        logic [AW-1:0] pcol;
        logic [AW-1:0] cq;
        logic          qc0;
        logic          qc1;
        logic          mtop;
        logic          mbot;
        logic          nms_ok;
        logic          last;
    } tok_t;

    // ---------------- configuration ----------------
    logic [10:0] fw_reg;
    logic [12:0] fh_reg;
    logic [9:0]  low_reg;
    logic [9:0]  high_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg   <= FRAME_WIDTH_RST;
            fh_reg   <= FRAME_HEIGHT_RST;
            low_reg  <= LOW_LEVEL_RST;
            high_reg <= HIGH_LEVEL_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  fw_reg   <= cfg_data[10:0];
                REG_FRAME_HEIGHT: fh_reg   <= cfg_data[12:0];
                REG_LOW_LEVEL:    low_reg  <= cfg_data[9:0];
                REG_HIGH_LEVEL:   high_reg <= cfg_data[9:0];
                default:          ;
            endcase
        end
    end

    // ---------------- position and frame size ----------------
    logic [AW-1:0]    col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [WW-1:0]    aw_reg;
    logic [ROW_W-1:0] ah_reg;
    logic [12:0]      fw_ext, fw_clamp, fh_clamp;
    logic [WW-1:0]    w_eff;
    logic [ROW_W-1:0] h_eff, rq;
    logic             pos0, step, col_last, wrap;
    tok_t             tok0;

    logic [OUT_CNT_W-1:0] cnt_reg, cnt_next;
    logic [OUT_CNT_W-1:0] infl_reg, infl_next;
    logic                 push, pop;

    assign in_ready = (({1'b0, cnt_reg} + {1'b0, infl_reg}) < (OUT_CNT_W + 1)'(OUT_DEPTH));

    always_comb
    begin
        fw_ext = {2'b00, fw_reg};
        if (fw_ext < 13'(MIN_SIZE))
            fw_clamp = 13'(MIN_SIZE);
        else if (fw_ext > 13'(MAX_WIDTH))
            fw_clamp = 13'(MAX_WIDTH);
        else
            fw_clamp = fw_ext;
        if (fh_reg < 13'(MIN_SIZE))
            fh_clamp = 13'(MIN_SIZE);
        else if (fh_reg > 13'(MAX_HEIGHT))
            fh_clamp = 13'(MAX_HEIGHT);
        else
            fh_clamp = fh_reg;
    end

    assign pos0     = (col_reg == '0) && (row_reg == '0);
    assign w_eff    = pos0 ? WW'(fw_clamp) : aw_reg;
    assign h_eff    = pos0 ? fh_clamp : ah_reg;
    assign step     = in_valid && in_ready && !(req_type && (row_reg < h_eff));
    assign col_last = (WW'(col_reg) == (w_eff - WW'(1)));
    assign wrap     = (row_reg == (h_eff + ROW_W'(2))) && (col_reg == AW'(1));
    assign rq       = (col_reg == '0) ? (row_reg - ROW_W'(2)) : (row_reg - ROW_W'(1));

    always_comb
    begin
        tok0.c0   = (col_reg == '0);
        tok0.c1   = (col_reg == AW'(1));
        tok0.ptop = (row_reg < ROW_W'(2));
        tok0.pbot = (row_reg >= h_eff);
        tok0.q_ok = (row_reg >= ROW_W'(2)) || ((row_reg == ROW_W'(1)) && (col_reg != '0));
        tok0.pcol = col_reg;
        tok0.cq   = (col_reg == '0) ? AW'(w_eff - WW'(1)) : (col_reg - AW'(1));
        // magnitude column 0 sits one beat behind, so col 1 / col 2 here
        tok0.qc0  = (col_reg == AW'(1));
        tok0.qc1  = (col_reg == AW'(2));
        tok0.mtop = (rq < ROW_W'(2));
        tok0.mbot = (rq >= h_eff);
        tok0.nms_ok = tok0.q_ok &&
                      ((rq >= ROW_W'(2)) || ((rq == ROW_W'(1)) && (col_reg != AW'(1))));
        tok0.last = wrap;
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (step)
        begin
            if (wrap)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (col_last)
            begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            aw_reg  <= WW'(FRAME_WIDTH_RST);
            ah_reg  <= FRAME_HEIGHT_RST;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (step && pos0)
            begin
                aw_reg <= w_eff;
                ah_reg <= h_eff;
            end
        end
    end

    // ---------------- pipeline valid bits ----------------
    logic [7:1] v_reg;
    tok_t       t1_reg, t2_reg, t3_reg, t4_reg, t5_reg, t6_reg, t7_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[6:1], step};
        end
    end

    always_ff @(posedge clk)
    begin
        t1_reg <= tok0;
        t2_reg <= t1_reg;
        t3_reg <= t2_reg;
        t4_reg <= t3_reg;
        t5_reg <= t4_reg;
        t6_reg <= t5_reg;
        t7_reg <= t6_reg;
    end

    // ---------------- S1: pixel line memory ----------------
    logic [7:0]  pix1_reg;
    logic [15:0] prd;
    pix_col_t    pcol1, pv2_reg, pp1_reg, pp2_reg;

    always_ff @(posedge clk)
    begin
        pix1_reg <= pixel_value;
    end

    // word holds {row-2, row-1} at each column
    sgnms_ram #(.WIDTH(16), .DEPTH(MAX_WIDTH)) u_pix_ram (
        .clk   (clk),
        .we    (v_reg[1]),
        .waddr (t1_reg.pcol),
        .wdata ({prd[7:0], pix1_reg}),
        .re    (step),
        .raddr (col_reg),
        .rdata (prd)
    );

    always_comb
    begin
        pcol1.mid = prd[7:0];
        pcol1.top = t1_reg.ptop ? prd[7:0] : prd[15:8];
        pcol1.bot = t1_reg.pbot ? prd[7:0] : pix1_reg;
    end

    always_ff @(posedge clk)
    begin
        pv2_reg <= pcol1;
    end

    // ---------------- S2: Sobel sums ----------------
    pix_col_t           pl, pr;
    logic [9:0]         lsum, rsum, tsum, bsum;
    logic signed [11:0] gx2, gy2;
    logic signed [11:0] gx3_reg, gy3_reg;

    always_comb
    begin
        pl   = t2_reg.c1 ? pp1_reg : pp2_reg;
        pr   = t2_reg.c0 ? pp1_reg : pv2_reg;
        lsum = 10'(pl.top) + {1'b0, pl.mid, 1'b0} + 10'(pl.bot);
        rsum = 10'(pr.top) + {1'b0, pr.mid, 1'b0} + 10'(pr.bot);
        tsum = 10'(pl.top) + {1'b0, pp1_reg.top, 1'b0} + 10'(pr.top);
        bsum = 10'(pl.bot) + {1'b0, pp1_reg.bot, 1'b0} + 10'(pr.bot);
        gx2  = $signed({2'b00, lsum}) - $signed({2'b00, rsum});
        gy2  = $signed({2'b00, tsum}) - $signed({2'b00, bsum});
    end

    always_ff @(posedge clk)
    begin
        gx3_reg <= gx2;
        gy3_reg <= gy2;
        if (v_reg[2])
        begin
            pp2_reg <= pp1_reg;
            pp1_reg <= pv2_reg;
        end
    end

    // ---------------- S3: clamp and absolute values ----------------
    logic signed [11:0] gxc, gyc;
    logic [8:0]         ax3, ay3, ax4_reg, ay4_reg;
    logic               gxz4_reg, gyz4_reg, sx4_reg, sy4_reg;

    always_comb
    begin
        if (gx3_reg > 12'sd510)
            gxc = 12'(GRAD_LIMIT);
        else if (gx3_reg < -12'sd510)
            gxc = -12'(GRAD_LIMIT);
        else
            gxc = gx3_reg;
        if (gy3_reg > 12'sd510)
            gyc = 12'(GRAD_LIMIT);
        else if (gy3_reg < -12'sd510)
            gyc = -12'(GRAD_LIMIT);
        else
            gyc = gy3_reg;
        ax3 = gxc[11] ? 9'(-gxc) : gxc[8:0];
        ay3 = gyc[11] ? 9'(-gyc) : gyc[8:0];
    end

    always_ff @(posedge clk)
    begin
        ax4_reg  <= ax3;
        ay4_reg  <= ay3;
        gxz4_reg <= (gxc == '0);
        gyz4_reg <= (gyc == '0);
        sx4_reg  <= gxc[11];
        sy4_reg  <= gyc[11];
    end

    // ---------------- S4: squares for the direction test ----------------
    logic [9:0]  mag4;
    logic [8:0]  dif4;
    logic [19:0] sqs5_reg;
    logic [18:0] sqt5_reg;
    logic [17:0] sqd5_reg;
    logic [9:0]  mag5_reg;
    logic        gtd5_reg, gxz5_reg, gyz5_reg, sx5_reg, sy5_reg;
    logic [21:0] mrd;

    assign mag4 = 10'(ax4_reg) + 10'(ay4_reg);
    assign dif4 = (ay4_reg > ax4_reg) ? (ay4_reg - ax4_reg) : '0;

    always_ff @(posedge clk)
    begin
        sqs5_reg <= 20'(mag4) * 20'(mag4);
        sqt5_reg <= {18'(ax4_reg) * 18'(ax4_reg), 1'b0};
        sqd5_reg <= 18'(dif4) * 18'(dif4);
        mag5_reg <= mag4;
        gtd5_reg <= (ay4_reg > ax4_reg);
        gxz5_reg <= gxz4_reg;
        gyz5_reg <= gyz4_reg;
        sx5_reg  <= sx4_reg;
        sy5_reg  <= sy4_reg;
    end

    // ---------------- S5: class and magnitude line memory ----------------
    dir_t     cls5;
    mag_col_t mcol5, mv6_reg, mp1_reg, mp2_reg;

    // word holds {mag row-2, mag row-1, dir row-1} at each column
    sgnms_ram #(.WIDTH(22), .DEPTH(MAX_WIDTH)) u_mag_ram (
        .clk   (clk),
        .we    (v_reg[5] && t5_reg.q_ok),
        .waddr (t5_reg.cq),
        .wdata ({mrd[11:2], mag5_reg, cls5}),
        .re    (v_reg[4] && t4_reg.q_ok),
        .raddr (t4_reg.cq),
        .rdata (mrd)
    );

    always_comb
    begin
        if (gxz5_reg)
            cls5 = gyz5_reg ? DIR_VERT : DIR_HORZ;
        else if (sqs5_reg < {1'b0, sqt5_reg})
            cls5 = DIR_VERT;
        else if (gtd5_reg && ({1'b0, sqd5_reg} > sqt5_reg))
            cls5 = DIR_HORZ;
        else
            cls5 = (sx5_reg != sy5_reg) ? DIR_BACK : DIR_SLASH;
        mcol5.top = t5_reg.mtop ? '0 : mrd[21:12];
        mcol5.mid = mrd[11:2];
        mcol5.bot = t5_reg.mbot ? '0 : mag5_reg;
        mcol5.dir = dir_t'(mrd[1:0]);
    end

    always_ff @(posedge clk)
    begin
        mv6_reg <= mcol5;
    end

    // ---------------- S6: suppression ----------------
    mag_col_t   ml, mr;
    logic [9:0] na, nb, sup6, mag7_reg;
    dir_t       dir7_reg;

    always_comb
    begin
        ml = t6_reg.qc1 ? '0 : mp2_reg;
        mr = t6_reg.qc0 ? '0 : mv6_reg;
        unique case (mp1_reg.dir)
            DIR_VERT:
            begin
                na = ml.mid;
                nb = mr.mid;
            end
            DIR_HORZ:
            begin
                na = mp1_reg.top;
                nb = mp1_reg.bot;
            end
            DIR_SLASH:
            begin
                na = ml.top;
                nb = mr.bot;
            end
            default:
            begin
                na = mr.top;
                nb = ml.bot;
            end
        endcase
        sup6 = ((na > mp1_reg.mid) || (nb > mp1_reg.mid)) ? '0 : mp1_reg.mid;
    end

    always_ff @(posedge clk)
    begin
        mag7_reg <= sup6;
        dir7_reg <= mp1_reg.dir;
        if (v_reg[6] && t6_reg.q_ok)
        begin
            mp2_reg <= mp1_reg;
            mp1_reg <= mv6_reg;
        end
    end

    // ---------------- S7: thresholds and output buffer ----------------
    localparam int OAW = $clog2(OUT_DEPTH);

    out_beat_t      obuf [OUT_DEPTH];
    out_beat_t      beat7, head;
    logic [OAW-1:0] wptr_reg, rptr_reg;

    always_comb
    begin
        beat7.mag  = mag7_reg;
        beat7.dir  = dir7_reg;
        beat7.lo   = (mag7_reg >= low_reg);
        beat7.hi   = (mag7_reg >= high_reg);
        beat7.last = t7_reg.last;
    end

    assign push      = v_reg[7] && t7_reg.nms_ok;
    assign pop       = out_valid && out_ready;
    assign cnt_next  = cnt_reg + OUT_CNT_W'(push) - OUT_CNT_W'(pop);
    assign infl_next = infl_reg + OUT_CNT_W'(step && tok0.nms_ok) - OUT_CNT_W'(push);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            obuf[wptr_reg] <= beat7;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            infl_reg <= '0;
            wptr_reg <= '0;
            rptr_reg <= '0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            infl_reg <= infl_next;
            if (push)
                wptr_reg <= wptr_reg + OAW'(1);
            if (pop)
                rptr_reg <= rptr_reg + OAW'(1);
        end
    end

    assign head           = obuf[rptr_reg];
    assign out_valid      = (cnt_reg != '0);
    assign edge_magnitude = head.mag;
    assign edge_direction = head.dir;
    assign above_low      = head.lo;
    assign above_high     = head.hi;
    assign frame_last     = head.last;

endmodule

/* hdl/sgnms_chk.sv */
// Port-level checker for the Sobel gradient / suppression core, bound to the top level.
// Depends on sgnms_pkg for the magnitude limit.
module sgnms_chk (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [9:0] edge_magnitude,
    input logic [1:0] edge_direction,
    input logic       above_low,
    input logic       above_high,
    input logic       frame_last
);

    import sgnms_pkg::*;

    // nothing leaves while held in reset
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result beat during reset");

    // a stalled beat stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(edge_magnitude) &&
        $stable(edge_direction) && $stable(above_low) && $stable(above_high) &&
        $stable(frame_last))
        else $error("stalled result beat changed");

    // |gx|+|gy| after clamping never exceeds twice the gradient limit
    a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> edge_magnitude <= 10'(MAG_MAX))
        else $error("magnitude out of range");

endmodule

bind sobel_gradient_nonmax_suppress_core sgnms_chk u_sgnms_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .edge_magnitude (edge_magnitude),
    .edge_direction (edge_direction),
    .above_low      (above_low),
    .above_high     (above_high),
    .frame_last     (frame_last)
);
